[src/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[src/eti_pkg.sv]
// Shared widths, codes and control types of the escape-time iterator.
package eti_pkg;

  // Coordinate and arithmetic widths (signed Q4.28 points, Q.56 products)
  localparam int COORD_W    = 32;
  localparam int FRAC_W     = 28;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int ORBIT_W    = 40;
  localparam int LIMIT_W    = COORD_W + 1;
  localparam int CFG_DATA_W = LIMIT_W;
  localparam int CFG_IDX_W  = 3;

  // Orbit magnitude of 8.0: any part at or beyond it escapes unconditionally
  localparam logic signed [ORBIT_W-1:0] BigPos = ORBIT_W'(64'sd1 <<< (FRAC_W + 3));
  localparam logic signed [ORBIT_W-1:0] BigNeg = -BigPos;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_RE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_IM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd4;

  // Datapath operation codes
  localparam logic [2:0] OP_HOLD  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_SQ_RE = 3'd2;
  localparam logic [2:0] OP_SQ_IM = 3'd3;
  localparam logic [2:0] OP_CROSS = 3'd4;
  localparam logic [2:0] OP_UPD   = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic       julia;
  } eti_ctrl_t;

  typedef struct packed {
    logic over_limit;
    logic big;
  } eti_stat_t;

endpackage

[src/eti_datapath.sv]
// Orbit registers and the shared multiplier of the escape-time iterator.
module eti_datapath import eti_pkg::*; (
  input  logic                      clk_i,
  input  eti_ctrl_t                 ctrl_i,
  input  logic signed [COORD_W-1:0] point_re_i,
  input  logic signed [COORD_W-1:0] point_im_i,
  input  logic signed [COORD_W-1:0] julia_re_i,
  input  logic signed [COORD_W-1:0] julia_im_i,
  input  logic        [LIMIT_W-1:0] limit_i,
  output eti_stat_t                 stat_o
);

  logic signed [COORD_W-1:0] orbit_re_q, orbit_im_q;
  logic signed [COORD_W-1:0] addend_re_q, addend_im_q;
  logic signed [PROD_W-1:0]  prod_q, rr_q, diff_q;

  logic signed [COORD_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [ORBIT_W-1:0] shr_re, shr_im, next_re, next_im;
  logic        [PROD_W-1:0]  mod_sq, limit_ext;

  // Select multiplier operands: re*re, im*im, then re*im
  always_comb begin
    mul_a = (ctrl_i.op == OP_SQ_IM) ? orbit_im_q : orbit_re_q;
    mul_b = (ctrl_i.op == OP_SQ_RE) ? orbit_re_q : orbit_im_q;
    mul_p = mul_a * mul_b;
  end

  // Form the next orbit with floor rounding, then add c
  always_comb begin
    shr_re  = ORBIT_W'(diff_q >>> FRAC_W);
    shr_im  = ORBIT_W'(prod_q >>> (FRAC_W - 1));
    next_re = shr_re + ORBIT_W'(addend_re_q);
    next_im = shr_im + ORBIT_W'(addend_im_q);
  end

  // Compare squared modulus (re^2 in rr_q, im^2 in prod_q) against the limit
  always_comb begin
    mod_sq    = $unsigned(rr_q) + $unsigned(prod_q);
    limit_ext = {{(PROD_W - LIMIT_W - FRAC_W){1'b0}}, limit_i, {FRAC_W{1'b0}}};
    stat_o.over_limit = (mod_sq > limit_ext);
    stat_o.big = (next_re >= BigPos) || (next_re <= BigNeg) ||
                 (next_im >= BigPos) || (next_im <= BigNeg);
  end

  // Advance the datapath one operation per cycle as the sequencer issues them; OP_HOLD keeps every register
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LOAD: begin
        if (ctrl_i.julia) begin
          orbit_re_q  <= point_re_i;
          orbit_im_q  <= point_im_i;
          addend_re_q <= julia_re_i;
          addend_im_q <= julia_im_i;
        end else begin
          orbit_re_q  <= '0;
          orbit_im_q  <= '0;
          addend_re_q <= point_re_i;
          addend_im_q <= point_im_i;
        end
      end
      OP_SQ_RE: begin
        prod_q <= mul_p;
      end
      OP_SQ_IM: begin
        rr_q   <= prod_q;
        prod_q <= mul_p;
      end
      OP_CROSS: begin
        diff_q <= rr_q - prod_q;
        prod_q <= mul_p;
      end
      OP_UPD: begin
        orbit_re_q <= next_re[COORD_W-1:0];
        orbit_im_q <= next_im[COORD_W-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

[src/escape_time_fractal_iterator_core.sv]
// Escape-time iterator: one complex point in, one escape count out.
// Each step runs re*re, im*im, re*im and then the update, sharing one 32x32 multiplier.
// A point ends when its modulus escapes, when its orbit grows too big, after n steps with
// no escape, or straight after loading when n is 0.
// One point at a time; the next is accepted once the result sits in the output register.
// Reset clears the sequencer and output valid and restores the register defaults.
module escape_time_fractal_iterator_core import eti_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_W-1:0]    point_re_i,
  input  logic signed [COORD_W-1:0]    point_im_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [COUNT_BITS-1:0]        escape_count_o,
  output logic                         escaped_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQ_RE = 3'd1;
  localparam logic [2:0] ST_SQ_IM = 3'd2;
  localparam logic [2:0] ST_CROSS = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Configuration registers
  logic                      mode_q;
  logic [COUNT_BITS-1:0]     max_iter_q;
  logic signed [COORD_W-1:0] julia_re_q, julia_im_q;
  logic [LIMIT_W-1:0]        limit_q;

  // Sequencer state
  logic [2:0]            state_q, state_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  chk_q, chk_d;
  logic [COUNT_BITS-1:0] pend_count_q, pend_count_d;
  logic                  pend_esc_q, pend_esc_d;
  logic                  out_valid_q, out_valid_d;
  logic [COUNT_BITS-1:0] out_count_q, out_count_d;
  logic                  out_esc_q, out_esc_d;

  logic      in_accept;
  eti_ctrl_t ctrl;
  eti_stat_t stat;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign in_accept      = in_valid_i && in_ready_o;
  assign out_valid_o    = out_valid_q;
  assign escape_count_o = out_count_q;
  assign escaped_o      = out_esc_q;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      max_iter_q <= COUNT_BITS'(250);
      julia_re_q <= 32'shCCCC_CCCD;
      julia_im_q <= '0;
      limit_q    <= 33'h0_4000_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:     mode_q     <= cfg_data_i[0];
        REG_MAX_ITER: max_iter_q <= cfg_data_i[COUNT_BITS-1:0];
        REG_JULIA_RE: julia_re_q <= cfg_data_i[COORD_W-1:0];
        REG_JULIA_IM: julia_im_q <= cfg_data_i[COORD_W-1:0];
        REG_LIMIT:    limit_q    <= cfg_data_i[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Step the sequencer from load through square, square, cross product and update to done
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    chk_d        = chk_q;
    pend_count_d = pend_count_q;
    pend_esc_d   = pend_esc_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_count_d  = out_count_q;
    out_esc_d    = out_esc_q;
    ctrl.op      = OP_HOLD;
    ctrl.julia   = mode_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          ctrl.op = OP_LOAD;
          cnt_d   = '0;
          chk_d   = 1'b0;
          if (max_iter_q == '0) begin
            pend_count_d = '0;
            pend_esc_d   = 1'b0;
            state_d      = ST_DONE;
          end else begin
            state_d = ST_SQ_RE;
          end
        end
      end
      ST_SQ_RE: begin
        ctrl.op = OP_SQ_RE;
        state_d = ST_SQ_IM;
      end
      ST_SQ_IM: begin
        ctrl.op = OP_SQ_IM;
        state_d = ST_CROSS;
      end
      ST_CROSS: begin
        ctrl.op = OP_CROSS;
        if (chk_q && stat.over_limit) begin
          pend_count_d = cnt_q - COUNT_BITS'(1);
          pend_esc_d   = 1'b1;
          state_d      = ST_DONE;
        end else if (chk_q && (cnt_q == max_iter_q)) begin
          pend_count_d = max_iter_q;
          pend_esc_d   = 1'b0;
          state_d      = ST_DONE;
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        ctrl.op = OP_UPD;
        chk_d   = 1'b1;
        if (stat.big) begin
          pend_count_d = cnt_q;
          pend_esc_d   = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cnt_d   = cnt_q + COUNT_BITS'(1);
          state_d = ST_SQ_RE;
        end
      end
      ST_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_count_d = pend_count_q;
          out_esc_d   = pend_esc_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state registers, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_count_q <= pend_count_d;
    pend_esc_q   <= pend_esc_d;
    out_count_q  <= out_count_d;
    out_esc_q    <= out_esc_d;
  end

  eti_datapath u_datapath (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .point_re_i (point_re_i),
    .point_im_i (point_im_i),
    .julia_re_i (julia_re_q),
    .julia_im_i (julia_im_q),
    .limit_i    (limit_q),
    .stat_o     (stat)
  );

endmodule

[src/eti_checker.sv]
// Port-level checks of the escape-time iterator and their bind to the top level.
`include "assert_macros.svh"

module eti_checker #(
  parameter int COUNT_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [COUNT_BITS-1:0] escape_count_o,
  input logic                  escaped_o
);

  // A point in flight blocks the input side
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // Ready drops only because a transaction was taken
  `ASSERT_NOW(a_ready_fall_on_accept, clk_i, rst_ni, $fell(in_ready_o), $past(in_valid_i))

  // A new result appears only after a busy period
  `ASSERT_NOW(a_result_after_busy, clk_i, rst_ni, $rose(out_valid_o), !$past(in_ready_o))

  // A stalled result holds
  `ASSERT_NEXT(a_result_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(escape_count_o) && $stable(escaped_o))

endmodule

bind escape_time_fractal_iterator_core eti_checker #(
  .COUNT_BITS(COUNT_BITS)
) u_eti_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .escape_count_o (escape_count_o),
  .escaped_o      (escaped_o)
);
